>>> hdl/assert_macros.svh
// Assertion macros shared by the page-fault tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define PFRT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define PFRT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> hdl/pfrt_pkg.sv
// Types, codes and helpers for the page-fault resolution tracker.
`default_nettype none

package pfrt_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMD_W      = 3;
    localparam int SLOT_W     = 4;
    localparam int GEN_W      = 64;
    localparam int SUM_W      = 64;
    localparam int CNT_W      = 16;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_RESET        = 3'd0,
        CMD_CLAIM        = 3'd1,
        CMD_REMOTE_BEGIN = 3'd2,
        CMD_REMOTE_DONE  = 3'd3,
        CMD_COPY_BEGIN   = 3'd4,
        CMD_RESOLVE      = 3'd5,
        CMD_FAIL         = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        PH_EMPTY      = 3'd0,
        PH_FAULT      = 3'd1,
        PH_READING    = 3'd2,
        PH_COPY_READY = 3'd3,
        PH_COPYING    = 3'd4,
        PH_RESOLVED   = 3'd5,
        PH_POISONED   = 3'd6,
        PH_FAILSTOP   = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        CL_OWNER     = 2'd0,
        CL_DUPLICATE = 2'd1,
        CL_STALE     = 2'd2
    } t_claim;

    // One slot record as held in the table memory.
    typedef struct packed {
        t_phase             phase;
        logic [GEN_W-1:0]   gen;
        logic [CNT_W-1:0]   waiters;
        logic [CNT_W-1:0]   reads;
        logic [SUM_W-1:0]   sum;
    } t_rec;

    // Status of one command after evaluation.
    typedef struct packed {
        logic   accepted;
        t_claim claim;
    } t_step_res;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

>>> hdl/pfrt_step.sv
// Next-record and status logic for one tracker command.
`default_nettype none

module pfrt_step (
    input  wire logic [pfrt_pkg::CMD_W-1:0] i_cmd,
    input  wire logic [pfrt_pkg::GEN_W-1:0] i_gen,
    input  wire logic [pfrt_pkg::SUM_W-1:0] i_sum,
    input  wire logic                       i_flag,
    input  wire pfrt_pkg::t_rec             i_cur,
    output pfrt_pkg::t_rec                  o_nxt,
    output pfrt_pkg::t_step_res             o_res
);
    import pfrt_pkg::*;

    logic match;

    assign match = (i_cur.gen == i_gen);

    // Phase transition per command
    always_comb begin
        o_nxt          = i_cur;
        o_res.accepted = 1'b0;
        o_res.claim    = CL_OWNER;
        unique case (t_cmd'(i_cmd))
            CMD_RESET: begin
                o_nxt.phase    = PH_EMPTY;
                o_nxt.waiters  = '0;
                o_nxt.reads    = '0;
                o_nxt.sum      = '0;
                o_nxt.gen      = i_gen;
                o_res.accepted = 1'b1;
            end
            CMD_CLAIM: begin
                if (i_gen == '0 || !match) begin
                    o_res.claim = CL_STALE;
                end else if (i_cur.phase == PH_EMPTY) begin
                    o_nxt.phase    = PH_FAULT;
                    o_nxt.waiters  = CNT_W'(1);
                    o_res.accepted = 1'b1;
                end else if (i_cur.phase >= PH_FAULT && i_cur.phase <= PH_RESOLVED) begin
                    o_nxt.waiters  = sat_inc(i_cur.waiters);
                    o_res.claim    = CL_DUPLICATE;
                    o_res.accepted = 1'b1;
                end else begin
                    o_res.claim = CL_STALE;
                end
            end
            CMD_REMOTE_BEGIN: begin
                if (match && i_cur.phase == PH_FAULT) begin
                    o_nxt.phase    = PH_READING;
                    o_nxt.reads    = sat_inc(i_cur.reads);
                    o_res.accepted = 1'b1;
                end
            end
            CMD_REMOTE_DONE: begin
                if (match && i_cur.phase == PH_READING) begin
                    o_nxt.phase    = PH_COPY_READY;
                    o_nxt.sum      = i_sum;
                    o_res.accepted = 1'b1;
                end
            end
            CMD_COPY_BEGIN: begin
                if (match && i_cur.phase == PH_COPY_READY) begin
                    o_nxt.phase    = PH_COPYING;
                    o_res.accepted = 1'b1;
                end
            end
            CMD_RESOLVE: begin
                // present page with a differing checksum is refused
                if (match && i_cur.phase == PH_COPYING &&
                    !(i_flag && i_sum != i_cur.sum)) begin
                    o_nxt.phase    = PH_RESOLVED;
                    o_res.accepted = 1'b1;
                end
            end
            CMD_FAIL: begin
                if (match && i_cur.phase >= PH_FAULT && i_cur.phase <= PH_COPYING) begin
                    o_nxt.phase    = i_flag ? PH_POISONED : PH_FAILSTOP;
                    o_res.accepted = 1'b1;
                end
            end
            default: begin
                o_nxt          = i_cur;
                o_res.accepted = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/page_fault_resolution_tracker_core.sv
// Pipeline: table read into stage 1, then update into the result register.
// Throughput: one command per cycle while the result is not stalled; a write to the slot just read is forwarded.
// Once stage 1 holds a command, a result stall stalls the input in the same cycle.
// Reset (synchronous, active low) clears pipeline valids and per-slot valid bits;
// a slot never written since reset reads as an all-zero record. No clearing pass.
`default_nettype none

module page_fault_resolution_tracker_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [pfrt_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic [pfrt_pkg::SLOT_W-1:0] i_slot,
    input  wire logic [pfrt_pkg::GEN_W-1:0]  i_generation,
    input  wire logic [pfrt_pkg::SUM_W-1:0]  i_checksum,
    input  wire logic                        i_flag,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_accepted,
    output logic [1:0]                       o_claim_result,
    output logic [2:0]                       o_phase,
    output logic [pfrt_pkg::CNT_W-1:0]       o_waiters,
    output logic [pfrt_pkg::CNT_W-1:0]       o_read_count
);
    import pfrt_pkg::*;

    // Record table and per-slot valid bits
    t_rec                   mem [SLOTS];
    logic [SLOTS-1:0]       r_ent_vld;

    // Stage 1: command waiting on table read data
    logic                   r_s1_valid;
    logic [CMD_W-1:0]       r_s1_cmd;
    logic [SLOT_IDX_W-1:0]  r_s1_idx;
    logic                   r_s1_in_range;
    logic [GEN_W-1:0]       r_s1_gen;
    logic [SUM_W-1:0]       r_s1_sum;
    logic                   r_s1_flag;
    t_rec                   r_rd_data;
    logic                   r_rd_vld;
    logic                   r_byp_hit;
    t_rec                   r_byp_data;

    // Output register
    logic                   r_out_valid;
    logic                   r_out_accepted;
    logic [1:0]             r_out_claim;
    logic [2:0]             r_out_phase;
    logic [CNT_W-1:0]       r_out_waiters;
    logic [CNT_W-1:0]       r_out_reads;

    logic                   accept;
    logic                   s1_adv;
    logic                   wr_en;
    logic                   in_range;
    logic [SLOT_IDX_W-1:0]  in_idx;
    t_rec                   cur;
    t_rec                   nxt;
    t_step_res              step_res;

    assign in_range   = (32'(i_slot) < SLOTS);
    assign in_idx     = SLOT_IDX_W'(i_slot);
    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign wr_en      = r_s1_valid && s1_adv && r_s1_in_range;

    // Operand: forwarded write, else table data, else reset record
    always_comb begin
        if (r_byp_hit) begin
            cur = r_byp_data;
        end else if (r_rd_vld) begin
            cur = r_rd_data;
        end else begin
            cur = '0;
        end
    end

    pfrt_step u_step (
        .i_cmd  (r_s1_cmd),
        .i_gen  (r_s1_gen),
        .i_sum  (r_s1_sum),
        .i_flag (r_s1_flag),
        .i_cur  (cur),
        .o_nxt  (nxt),
        .o_res  (step_res)
    );

    // Table memory: write-back of updated record, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_s1_idx] <= nxt;
        end
        if (accept) begin
            r_rd_data <= mem[in_idx];
        end
    end

    // Slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (wr_en) begin
            r_ent_vld[r_s1_idx] <= 1'b1;
        end
    end

    // Stage 1 capture, with forwarding of a same-cycle write to the same slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp_hit  <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_byp_hit  <= wr_en && (r_s1_idx == in_idx);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
            r_byp_hit  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd      <= i_cmd;
            r_s1_idx      <= in_idx;
            r_s1_in_range <= in_range;
            r_s1_gen      <= i_generation;
            r_s1_sum      <= i_checksum;
            r_s1_flag     <= i_flag;
            r_rd_vld      <= r_ent_vld[in_idx];
            r_byp_data    <= nxt;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            if (r_s1_in_range) begin
                r_out_accepted <= step_res.accepted;
                r_out_claim    <= step_res.claim;
                r_out_phase    <= nxt.phase;
                r_out_waiters  <= nxt.waiters;
                r_out_reads    <= nxt.reads;
            end else begin
                r_out_accepted <= 1'b0;
                r_out_claim    <= (t_cmd'(r_s1_cmd) == CMD_CLAIM) ? CL_STALE : CL_OWNER;
                r_out_phase    <= PH_EMPTY;
                r_out_waiters  <= '0;
                r_out_reads    <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_out_accepted;
    assign o_claim_result = r_out_claim;
    assign o_phase        = r_out_phase;
    assign o_waiters      = r_out_waiters;
    assign o_read_count   = r_out_reads;

    `include "assert_macros.svh"

    `PFRT_ASSERT(a_accept_not_stale, o_out_valid && o_accepted |-> o_claim_result != CL_STALE, "accepted command reported stale")
    `PFRT_ASSERT(a_s1_to_out, r_s1_valid && s1_adv |=> o_out_valid, "stage 1 command lost before output")
    `PFRT_ASSERT(a_byp_needs_s1, r_byp_hit |-> r_s1_valid, "forwarding flag without a command in stage 1")
    `PFRT_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !r_s1_valid && !r_out_valid, "pipeline not cleared by reset")

endmodule

`default_nettype wire
